### hdl/sample_math_operator_core_macros.svh
// ----------------------------------------------------------------------------
// sample math operator core assertion macros
// shared concurrent assertion forms clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef SAMPLE_MATH_OPERATOR_CORE_MACROS_SVH
`define SAMPLE_MATH_OPERATOR_CORE_MACROS_SVH

// same-cycle implication
`define SMO_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SMO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/smo_pkg.sv
// ----------------------------------------------------------------------------
// smo_pkg
// types, constants and helpers of the sample math operator pipeline
// ----------------------------------------------------------------------------
package smo_pkg;

  typedef enum logic [3:0] {
    OP_MIN  = 4'd0,
    OP_MAX  = 4'd1,
    OP_MEAN = 4'd2,
    OP_DIV  = 4'd3,
    OP_INV  = 4'd4,
    OP_REM  = 4'd5,
    OP_TANH = 4'd6,
    OP_ATAN = 4'd7,
    OP_PASS = 4'd8
  } op_e;

  localparam int CORDIC_STAGES  = 30;
  localparam int EXP_TERMS      = 14;
  localparam int HORNER_DEPTH   = 3;
  localparam int DIV_STAGES     = 48;
  localparam int DIV_IN_STAGE   = 2 + EXP_TERMS * HORNER_DEPTH;
  localparam int LAST_STAGE     = DIV_IN_STAGE + DIV_STAGES;

  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [29:0] LN2_Q30     = 30'd744261118;
  localparam logic [17:0] LN2_RECIP   = 18'd189096;
  localparam logic [31:0] TEN_K_Q16   = 32'd655360000;
  localparam logic [31:0] ONE_Q16     = 32'd65536;
  localparam logic [31:0] ATAN_ROUND  = 32'd8192;

  localparam logic [29:0] ATAN_Q30 [CORDIC_STAGES] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
    30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536,
    30'd32768, 30'd16384, 30'd8192, 30'd4096, 30'd2048,
    30'd1024, 30'd512, 30'd256, 30'd128, 30'd64,
    30'd32, 30'd16, 30'd8, 30'd4, 30'd2
  };

  // floor((2^32 - 1) / k) for k = 1 .. 14, index k - 1
  localparam logic [31:0] HORNER_RECIP [EXP_TERMS] = '{
    32'd4294967295, 32'd2147483647, 32'd1431655765, 32'd1073741823,
    32'd858993459, 32'd715827882, 32'd613566756, 32'd536870911,
    32'd477218588, 32'd429496729, 32'd390451572, 32'd357913941,
    32'd330382099, 32'd306783378
  };

  typedef struct packed {
    logic [3:0]         op;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic [4:0]         n;
    logic signed [31:0] z;
  } side_t;

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    logic [31:0] r;
    r = v[31] ? (~v + 32'd1) : v;
    return r;
  endfunction

  function automatic logic [31:0] sat_quot(input logic [47:0] q, input logic neg);
    logic [31:0] r;
    if (!neg) begin
      r = (q > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    end else begin
      r = (q > 48'h0000_8000_0000) ? 32'h8000_0000 : (32'd0 - q[31:0]);
    end
    return r;
  endfunction

endpackage

### hdl/smo_horner_cell.sv
// ----------------------------------------------------------------------------
// smo_horner_cell
// one term of the exp(-r) series: acc = 1 - ((r * acc) >> 30) / k, 3 stages
// ----------------------------------------------------------------------------
module smo_horner_cell (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [3:0]  k_i,
  input  logic [31:0] recip_i,
  input  logic [29:0] r_i,
  input  logic [30:0] acc_i,
  output logic [29:0] r_o,
  output logic [30:0] acc_o
);

  logic [60:0] prod_a;
  logic [61:0] prod_b;
  logic [33:0] back;
  logic [30:0] diff;
  logic [29:0] quot;

  logic [29:0] p_a_q, r_a_q;
  logic [29:0] p_b_q, r_b_q, qe_b_q;
  logic [29:0] r_c_q;
  logic [30:0] acc_c_q;

  assign prod_a = 61'(r_i) * 61'(acc_i);
  assign prod_b = 62'(p_a_q) * 62'(recip_i);
  assign back   = 34'(qe_b_q) * 34'(k_i);
  assign diff   = {1'b0, p_b_q} - back[30:0];
  assign quot   = (diff >= 31'(k_i)) ? (qe_b_q + 30'd1) : qe_b_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_a_q   <= prod_a[59:30];
      r_a_q   <= r_i;
      p_b_q   <= p_a_q;
      qe_b_q  <= prod_b[61:32];
      r_b_q   <= r_a_q;
      acc_c_q <= smo_pkg::Q30_ONE - {1'b0, quot};
      r_c_q   <= r_b_q;
    end
  end

  assign r_o   = r_c_q;
  assign acc_o = acc_c_q;

endmodule

### hdl/smo_cordic_cell.sv
// ----------------------------------------------------------------------------
// smo_cordic_cell
// one vectoring rotation of the atan unit
// ----------------------------------------------------------------------------
module smo_cordic_cell (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [4:0]         sh_i,
  input  logic [29:0]        angle_i,
  input  logic signed [47:0] x_i,
  input  logic signed [47:0] y_i,
  input  logic signed [31:0] z_i,
  output logic signed [47:0] x_o,
  output logic signed [47:0] y_o,
  output logic signed [31:0] z_o
);

  logic signed [47:0] dx, dy;
  logic signed [31:0] ang;
  logic signed [47:0] x_q, y_q;
  logic signed [31:0] z_q;

  assign dx  = y_i >>> sh_i;
  assign dy  = x_i >>> sh_i;
  assign ang = signed'({2'b00, angle_i});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (y_i > 48'sd0) begin
        x_q <= x_i + dx;
        y_q <= y_i - dy;
        z_q <= z_i + ang;
      end else begin
        x_q <= x_i - dx;
        y_q <= y_i + dy;
        z_q <= z_i - ang;
      end
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

### hdl/smo_div_cell.sv
// ----------------------------------------------------------------------------
// smo_div_cell
// one restoring step of the unsigned 48 by 32 bit divider
// ----------------------------------------------------------------------------
module smo_div_cell (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] rem_i,
  input  logic [47:0] num_i,
  input  logic [31:0] den_i,
  output logic [31:0] rem_o,
  output logic [47:0] num_o,
  output logic [31:0] den_o
);

  logic [32:0] trial, diff;
  logic        ge;
  logic [31:0] rem_q, den_q;
  logic [47:0] num_q;

  assign trial = {rem_i, num_i[47]};
  assign diff  = trial - {1'b0, den_i};
  assign ge    = trial >= {1'b0, den_i};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= ge ? diff[31:0] : trial[31:0];
      num_q <= {num_i[46:0], ge};
      den_q <= den_i;
    end
  end

  assign rem_o = rem_q;
  assign num_o = num_q;
  assign den_o = den_q;

endmodule

### hdl/sample_math_operator_core.sv
// ----------------------------------------------------------------------------
// sample_math_operator_core
// min, max, mean, divide, inverse, remainder, tanh, atan or pass of Q15.16
//
//   channel   dir  beat contents
//   s_axis    in   tdata[31:0] sample_a, tdata[63:32] sample_b
//   m_axis    out  tdata[31:0] result_sample
//   cfg       in   cfg_wdata_i operation, written when cfg_we_i is high
//
// one beat per cycle while m_axis_tready does not stall the output
// stages are range reduction and tanh series cells (44), the divider operand
// register, the 48 divider cells and the output register
// the whole pipeline advances together; a stalled output holds every stage
// reset clears the valid bits and sets the operation to pass-through
// ----------------------------------------------------------------------------
`include "sample_math_operator_core_macros.svh"

module sample_math_operator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // sample_a, sample_b
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // result_sample
);

  localparam int LAST = smo_pkg::LAST_STAGE;
  localparam int DIN  = smo_pkg::DIV_IN_STAGE;
  localparam int NCOR = smo_pkg::CORDIC_STAGES;
  localparam int NEXP = smo_pkg::EXP_TERMS;
  localparam int NDIV = smo_pkg::DIV_STAGES;

  logic                en;
  logic [3:0]          op_q;
  logic [LAST:0]       valid_q;
  logic                m_valid_q;
  logic [31:0]         m_data_q;
  smo_pkg::side_t      side_q [LAST+1];
  logic signed [31:0]  a_in, b_in;

  // tanh range reduction
  logic [31:0] abs_in;
  logic [36:0] n0_prod;
  logic [18:0] mag_q;
  logic [4:0]  n0_q;
  logic [34:0] y_red, ln2_mul, red_diff;
  logic        red_ge;
  logic [29:0] r_q;
  logic [4:0]  n_d;

  logic [29:0] hr_r   [NEXP+1];
  logic [30:0] hr_acc [NEXP+1];

  logic signed [47:0] cx [NCOR+1];
  logic signed [47:0] cy [NCOR+1];
  logic signed [31:0] cz [NCOR+1];

  logic [31:0] dv_rem [NDIV+1];
  logic [47:0] dv_num [NDIV+1];
  logic [31:0] dv_den [NDIV+1];
  logic [47:0] dv_num_q;
  logic [31:0] dv_den_q;

  // divider operand setup
  smo_pkg::side_t sd;
  logic [30:0] t_val;
  logic [31:0] tanh_den;
  logic [47:0] num_d;
  logic [31:0] den_d;

  // result select
  smo_pkg::side_t sf;
  logic [32:0]        sum_ab;
  logic signed [31:0] z_rnd;
  logic [31:0]        res_d;

  assign en            = !m_valid_q || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign a_in          = signed'(s_axis_tdata[31:0]);
  assign b_in          = signed'(s_axis_tdata[63:32]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= smo_pkg::OP_PASS;
    end else if (cfg_we_i) begin
      op_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      m_valid_q <= 1'b0;
    end else if (en) begin
      valid_q   <= {valid_q[LAST-1:0], s_axis_tvalid};
      m_valid_q <= valid_q[LAST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= '{op: op_q, a: a_in, b: b_in, n: 5'd0, z: 32'sd0};
      side_q[1] <= '{op: side_q[0].op, a: side_q[0].a, b: side_q[0].b,
                     n: n_d, z: side_q[0].z};
      for (int s = 2; s <= LAST; s++) begin
        if (s != NCOR) begin
          side_q[s] <= side_q[s-1];
        end
      end
      side_q[NCOR] <= '{op: side_q[NCOR-1].op, a: side_q[NCOR-1].a,
                        b: side_q[NCOR-1].b, n: side_q[NCOR-1].n, z: cz[NCOR]};
    end
  end

  // tanh: split 2|a| into n * ln2 + r
  assign abs_in  = smo_pkg::abs32(a_in);
  assign n0_prod = 37'(abs_in[18:0]) * 37'(smo_pkg::LN2_RECIP);

  assign y_red    = {1'b0, mag_q, 15'd0};
  assign ln2_mul  = 35'(n0_q) * 35'(smo_pkg::LN2_Q30);
  assign red_diff = y_red - ln2_mul;
  assign red_ge   = red_diff >= 35'(smo_pkg::LN2_Q30);
  assign n_d      = red_ge ? (n0_q + 5'd1) : n0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q <= abs_in[18:0];
      n0_q  <= n0_prod[36:32];
      r_q   <= red_ge ? 30'(red_diff - 35'(smo_pkg::LN2_Q30)) : red_diff[29:0];
    end
  end

  assign hr_r[0]   = r_q;
  assign hr_acc[0] = smo_pkg::Q30_ONE;

  for (genvar j = 0; j < NEXP; j++) begin : g_horner
    smo_horner_cell u_cell (
      .clk_i   (clk_i),
      .en_i    (en),
      .k_i     (4'(NEXP - j)),
      .recip_i (smo_pkg::HORNER_RECIP[NEXP-1-j]),
      .r_i     (hr_r[j]),
      .acc_i   (hr_acc[j]),
      .r_o     (hr_r[j+1]),
      .acc_o   (hr_acc[j+1])
    );
  end

  // atan vectoring chain
  assign cx[0] = 48'sd1073741824;
  assign cy[0] = signed'({{2{a_in[31]}}, a_in, 14'd0});
  assign cz[0] = 32'sd0;

  for (genvar i = 0; i < NCOR; i++) begin : g_cordic
    smo_cordic_cell u_cell (
      .clk_i   (clk_i),
      .en_i    (en),
      .sh_i    (5'(i)),
      .angle_i (smo_pkg::ATAN_Q30[i]),
      .x_i     (cx[i]),
      .y_i     (cy[i]),
      .z_i     (cz[i]),
      .x_o     (cx[i+1]),
      .y_o     (cy[i+1]),
      .z_o     (cz[i+1])
    );
  end

  // divider operands
  assign sd       = side_q[DIN-1];
  assign t_val    = hr_acc[NEXP] >> sd.n;
  assign tanh_den = 32'(smo_pkg::Q30_ONE) + 32'(t_val);

  always_comb begin
    num_d = '0;
    den_d = '0;
    unique case (sd.op)
      smo_pkg::OP_DIV: begin
        num_d = {smo_pkg::abs32(sd.a), 16'd0};
        den_d = smo_pkg::abs32(sd.b);
      end
      smo_pkg::OP_INV: begin
        num_d = 48'h0001_0000_0000;
        den_d = smo_pkg::abs32(sd.a);
      end
      smo_pkg::OP_REM: begin
        num_d = 48'(smo_pkg::abs32(sd.a));
        den_d = smo_pkg::abs32(sd.b);
      end
      smo_pkg::OP_TANH: begin
        num_d = {1'b0, smo_pkg::Q30_ONE - t_val, 16'd0} + 48'(tanh_den[31:1]);
        den_d = tanh_den;
      end
      default: begin
        num_d = '0;
        den_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_num_q <= num_d;
      dv_den_q <= den_d;
    end
  end

  assign dv_rem[0] = '0;
  assign dv_num[0] = dv_num_q;
  assign dv_den[0] = dv_den_q;

  for (genvar d = 0; d < NDIV; d++) begin : g_div
    smo_div_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .rem_i (dv_rem[d]),
      .num_i (dv_num[d]),
      .den_i (dv_den[d]),
      .rem_o (dv_rem[d+1]),
      .num_o (dv_num[d+1]),
      .den_o (dv_den[d+1])
    );
  end

  // result select
  assign sf     = side_q[LAST];
  assign sum_ab = {sf.a[31], sf.a} + {sf.b[31], sf.b};
  assign z_rnd  = (sf.z + signed'(smo_pkg::ATAN_ROUND)) >>> 14;

  always_comb begin
    res_d = sf.a;
    unique case (sf.op)
      smo_pkg::OP_MIN:  res_d = (sf.a > sf.b) ? sf.b : sf.a;
      smo_pkg::OP_MAX:  res_d = (sf.a > sf.b) ? sf.a : sf.b;
      smo_pkg::OP_MEAN: res_d = sum_ab[32:1];
      smo_pkg::OP_DIV: begin
        res_d = (sf.b == 32'sd0) ? smo_pkg::TEN_K_Q16
              : smo_pkg::sat_quot(dv_num[NDIV], sf.a[31] ^ sf.b[31]);
      end
      smo_pkg::OP_INV: begin
        res_d = (sf.a == 32'sd0) ? smo_pkg::TEN_K_Q16
              : smo_pkg::sat_quot(dv_num[NDIV], sf.a[31]);
      end
      smo_pkg::OP_REM: begin
        if (sf.b == 32'sd0) begin
          res_d = '0;
        end else begin
          res_d = sf.a[31] ? (32'd0 - dv_rem[NDIV]) : dv_rem[NDIV];
        end
      end
      smo_pkg::OP_TANH: begin
        if (smo_pkg::abs32(sf.a) >= 32'd524288) begin
          res_d = sf.a[31] ? (32'd0 - smo_pkg::ONE_Q16) : smo_pkg::ONE_Q16;
        end else begin
          res_d = sf.a[31] ? (32'd0 - dv_num[NDIV][31:0]) : dv_num[NDIV][31:0];
        end
      end
      smo_pkg::OP_ATAN: res_d = z_rnd;
      default:          res_d = sf.a;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_data_q <= res_d;
    end
  end

  `SMO_ASSERT_NEXT(a_accept_enters, s_axis_tvalid && s_axis_tready, valid_q[0],
                   "accepted beat lost at entry")
  `SMO_ASSERT_NEXT(a_stall_holds, !s_axis_tready, $stable(valid_q),
                   "pipeline moved during stall")
  `SMO_ASSERT_NEXT(a_last_drains, s_axis_tready && valid_q[LAST], m_axis_tvalid,
                   "finished beat not presented")
  `SMO_ASSERT_IMP(a_blocked_output, m_axis_tvalid && !m_axis_tready, !s_axis_tready,
                  "input open while output blocked")

endmodule
